FILE: rtl/fixed_partition_allocator_defines.svh
// Assertion macros shared by the fixed partition allocator RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef FIXED_PARTITION_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_ALLOCATOR_DEFINES_SVH

// property must hold at every edge outside reset
`define FPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// expression must never be true outside reset
`define FPA_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

FILE: rtl/fpa_pkg.sv
// Types, field widths and codes of the fixed partition allocator.
// No dependencies; used by every module of the block but fpa_ram.
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int unsigned DATA_W     = 24;
  localparam int unsigned PID_W      = 16;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned TAKEN_W    = 8;
  localparam int unsigned FRAG_W     = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned DIV_CNT_W  = 5;

  localparam int unsigned IN_USED_W  = ACT_W + PID_W + DATA_W;
  localparam int unsigned IN_W       = ((IN_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_USED_W = CODE_W + TAKEN_W + FRAG_W;
  localparam int unsigned OUT_W      = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [FRAG_W-1:0] FRAG_MAX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } fpa_action_e;

  typedef enum logic [CODE_W-1:0] {
    RES_OK            = 2'd0,
    RES_NO_MEMORY     = 2'd1,
    RES_NOT_ALLOCATED = 2'd2
  } fpa_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEMORY_SIZE    = 2'd0,
    REG_PARTITION_SIZE = 2'd1
  } fpa_reg_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_ALLOC = 2'd2,
    MODE_SCAN  = 2'd3
  } fpa_mode_e;

  typedef struct packed {
    logic      load_req;
    logic      div_start;
    logic      div_need;
    logic      latch_n;
    logic      latch_need;
    logic      clear_scan;
    logic      clear_count;
    fpa_mode_e mode;
    logic      load_out;
  } fpa_cmd_t;

  typedef struct packed {
    fpa_action_e action;
    logic        div_done;
    logic        pass_done;
    logic        alloc_ok;
  } fpa_status_t;

endpackage

FILE: rtl/fixed_partition_allocator.sv
// Top level of the fixed partition allocator: stream ports, config port.
// Depends on fpa_pkg, fpa_ctrl and fpa_dp.
//
//   channel   handshake                       payload
//   request   s_axis_tvalid / s_axis_tready   s_axis_tdata
//   result    m_axis_tvalid / m_axis_tready   m_axis_tdata
//   config    cfg_we_i                        cfg_index_i, cfg_data_i
//
// One request at a time. A shared divider gives the usable partition count n and, on allocate,
// the partitions needed; walks take one partition a cycle.
// Partition used flags clear at reset; no clearing pass.
// A result held by a stalled m_axis_tready blocks the next result load, and with it the next accept.
`timescale 1ns / 1ps

module fixed_partition_allocator #(
  parameter int unsigned MAX_PARTITIONS = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // action[1:0], process_id[17:2], request_size[41:18], zero pad
  input  logic [fpa_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_code[1:0], partitions_taken[9:2], fragmented_bytes[40:10], zero pad
  output logic [fpa_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fpa_pkg::DATA_W-1:0]     cfg_data_i
);

  fpa_pkg::fpa_cmd_t    cmd;
  fpa_pkg::fpa_status_t sts;

  fpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fpa_dp #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: rtl/fpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fpa_div.sv
// Restoring divider, one quotient bit per cycle, for the partition counts.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fpa_pkg::DATA_W-1:0] dividend_i,
  input  logic [fpa_pkg::DATA_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [fpa_pkg::DATA_W-1:0] quotient_o,
  output logic                      rem_nz_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [fpa_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [fpa_pkg::DATA_W-1:0]     quo_q, quo_d;
  logic [fpa_pkg::DATA_W-1:0]     rem_q, rem_d;
  logic [fpa_pkg::DATA_W-1:0]     div_q, div_d;
  logic [fpa_pkg::DATA_W:0]       shifted;
  logic [fpa_pkg::DATA_W:0]       diff;
  logic                           fits;

  always_comb begin
    shifted = {rem_q, quo_q[fpa_pkg::DATA_W-1]};
    diff    = shifted - {1'b0, div_q};
    fits    = (shifted >= {1'b0, div_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = fpa_pkg::DIV_CNT_W'(fpa_pkg::DATA_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[fpa_pkg::DATA_W-2:0], fits};
      rem_d = fits ? diff[fpa_pkg::DATA_W-1:0] : shifted[fpa_pkg::DATA_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == fpa_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_nz_o   = |rem_q;

endmodule

FILE: rtl/fpa_ctrl.sv
// Request sequencer of the fixed partition allocator: divide, count, allocate, scan.
// Depends on fpa_pkg and fixed_partition_allocator_defines.svh.
`timescale 1ns / 1ps
`include "fixed_partition_allocator_defines.svh"

module fpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  input  fpa_pkg::fpa_status_t sts_i,
  output fpa_pkg::fpa_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIVN  = 7'b0000010,
    ST_DIVQ  = 7'b0000100,
    ST_COUNT = 7'b0001000,
    ST_ALLOC = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mode = fpa_pkg::MODE_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_req  = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (sts_i.div_done) begin
          cmd_o.latch_n     = 1'b1;
          cmd_o.clear_scan  = 1'b1;
          cmd_o.clear_count = 1'b1;
          case (sts_i.action)
            fpa_pkg::ACT_ALLOC: begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_need  = 1'b1;
              state_d         = ST_DIVQ;
            end
            fpa_pkg::ACT_FREE, fpa_pkg::ACT_QUERY: begin
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DIVQ: begin
        if (sts_i.div_done) begin
          cmd_o.latch_need = 1'b1;
          state_d          = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd_o.mode = fpa_pkg::MODE_COUNT;
        if (sts_i.pass_done) begin
          if (sts_i.alloc_ok) begin
            cmd_o.clear_scan = 1'b1;
            state_d          = ST_ALLOC;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_ALLOC: begin
        cmd_o.mode = fpa_pkg::MODE_ALLOC;
        if (sts_i.pass_done) begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.mode = fpa_pkg::MODE_SCAN;
        if (sts_i.pass_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

  `FPA_ASSERT(a_busy_after_accept, (s_valid_i && s_ready_o) |=> !s_ready_o,
              "request accepted while the previous one is still in work")
  `FPA_ASSERT(a_result_shown, cmd_o.load_out |=> m_valid_o,
              "loaded result not presented")
  `FPA_ASSERT_NEVER(a_result_clobber, cmd_o.load_out && m_valid_o && !m_ready_i,
                    "pending result overwritten")

endmodule

FILE: rtl/fpa_dp.sv
// Datapath of the fixed partition allocator: config, divider, partition table, result.
// Depends on fpa_pkg, fpa_div, fpa_ram and fixed_partition_allocator_defines.svh.
`timescale 1ns / 1ps
`include "fixed_partition_allocator_defines.svh"

module fpa_dp #(
  parameter int unsigned MAX_PARTITIONS = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fpa_pkg::DATA_W-1:0]      cfg_data_i,
  input  logic [fpa_pkg::IN_W-1:0]        in_data_i,
  input  fpa_pkg::fpa_cmd_t               cmd_i,
  output fpa_pkg::fpa_status_t            sts_o,
  output logic [fpa_pkg::OUT_W-1:0]       out_data_o
);

  localparam int unsigned CW      = $clog2(MAX_PARTITIONS + 1);
  localparam int unsigned IW      = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned DATA_W  = fpa_pkg::DATA_W;
  localparam int unsigned PID_W   = fpa_pkg::PID_W;
  localparam int unsigned FRAG_W  = fpa_pkg::FRAG_W;
  localparam int unsigned ENTRY_W = DATA_W + PID_W;
  localparam int unsigned OUT_PAD = fpa_pkg::OUT_W - fpa_pkg::OUT_USED_W;

  logic [DATA_W-1:0]          mem_size_q, part_size_q;
  fpa_pkg::fpa_action_e       action_q;
  logic [PID_W-1:0]           pid_q;
  logic [DATA_W-1:0]          req_q;
  logic [CW-1:0]              n_q, n_d;
  logic [DATA_W-1:0]          need_q, need_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic                       pv_q, pv_d;
  logic [IW-1:0]              pidx_q;
  logic [CW-1:0]              freecnt_q, freecnt_d;
  logic [CW-1:0]              taken_q, taken_d;
  logic [DATA_W-1:0]          left_q, left_d;
  logic [FRAG_W-1:0]          acc_q, acc_d;
  logic                       found_q, found_d;
  logic [MAX_PARTITIONS-1:0]  used_q, used_d;
  fpa_pkg::fpa_code_e         code_q, code_d;
  logic [fpa_pkg::TAKEN_W-1:0] otaken_q, otaken_d;
  logic [FRAG_W-1:0]          ofrag_q, ofrag_d;

  logic [DATA_W-1:0]  div_quo;
  logic               div_rem_nz;
  logic               div_done;
  logic [IW-1:0]      idx_ix;
  logic               idx_more;
  logic               alloc_end;
  logic               alloc_ok;
  logic               pass_done;
  logic               left_ge;
  logic [DATA_W-1:0]  new_leftover;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [PID_W-1:0]   rd_owner;
  logic [DATA_W-1:0]  rd_left;
  logic [FRAG_W:0]    frag_sum;
  logic [DATA_W-1:0]  taken_ext;

  fpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_need ? req_q : mem_size_q),
    .divisor_i  (part_size_q),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .rem_nz_o   (div_rem_nz)
  );

  fpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PARTITIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_ix),
    .wdata_i ({new_leftover, pid_q}),
    .raddr_i (idx_ix),
    .rdata_o (ram_rdata)
  );

  assign rd_owner  = ram_rdata[PID_W-1:0];
  assign rd_left   = ram_rdata[ENTRY_W-1:PID_W];
  assign idx_ix    = idx_q[IW-1:0];
  assign idx_more  = (idx_q != n_q);
  assign alloc_end = !idx_more || (DATA_W'(taken_q) == need_q);
  assign alloc_ok  = (need_q <= DATA_W'(freecnt_q));
  assign left_ge   = (left_q >= part_size_q);
  assign new_leftover = left_ge ? '0 : (part_size_q - left_q);
  assign ram_we    = (cmd_i.mode == fpa_pkg::MODE_ALLOC) && !alloc_end && !used_q[idx_ix];
  assign frag_sum  = {1'b0, acc_q} + (FRAG_W + 1)'(rd_left);
  assign taken_ext = DATA_W'(taken_q);

  always_comb begin
    case (cmd_i.mode)
      fpa_pkg::MODE_COUNT: pass_done = !idx_more;
      fpa_pkg::MODE_ALLOC: pass_done = alloc_end;
      fpa_pkg::MODE_SCAN:  pass_done = !idx_more && !pv_q;
      default:             pass_done = 1'b0;
    endcase
  end

  always_comb begin
    sts_o.action    = action_q;
    sts_o.div_done  = div_done;
    sts_o.pass_done = pass_done;
    sts_o.alloc_ok  = alloc_ok;
  end

  // partition count and partitions needed from the divider
  always_comb begin
    n_d = n_q;
    if (cmd_i.latch_n) begin
      if (part_size_q == '0) begin
        n_d = '0;
      end else if (div_quo > DATA_W'(MAX_PARTITIONS)) begin
        n_d = CW'(MAX_PARTITIONS);
      end else begin
        n_d = div_quo[CW-1:0];
      end
    end
    need_d = need_q;
    if (cmd_i.latch_need) begin
      if (part_size_q == '0) begin
        need_d = DATA_W'(req_q != '0);
      end else begin
        need_d = div_quo + DATA_W'(div_rem_nz);
      end
    end
  end

  // partition walk
  always_comb begin
    idx_d     = idx_q;
    pv_d      = 1'b0;
    freecnt_d = freecnt_q;
    taken_d   = taken_q;
    left_d    = left_q;
    acc_d     = acc_q;
    found_d   = found_q;
    used_d    = used_q;
    if (cmd_i.clear_scan) begin
      idx_d   = '0;
      taken_d = '0;
      left_d  = req_q;
      acc_d   = '0;
      found_d = 1'b0;
    end else begin
      case (cmd_i.mode)
        fpa_pkg::MODE_COUNT: begin
          if (idx_more) begin
            freecnt_d = freecnt_q + CW'(!used_q[idx_ix]);
            idx_d     = idx_q + 1'b1;
          end
        end
        fpa_pkg::MODE_ALLOC: begin
          if (!alloc_end) begin
            if (!used_q[idx_ix]) begin
              used_d[idx_ix] = 1'b1;
              taken_d        = taken_q + 1'b1;
              left_d         = left_ge ? (left_q - part_size_q) : '0;
            end
            idx_d = idx_q + 1'b1;
          end
        end
        fpa_pkg::MODE_SCAN: begin
          if (idx_more) begin
            pv_d  = 1'b1;
            idx_d = idx_q + 1'b1;
          end
          if (pv_q && used_q[pidx_q]) begin
            if (action_q == fpa_pkg::ACT_FREE) begin
              if (rd_owner == pid_q) begin
                used_d[pidx_q] = 1'b0;
                found_d        = 1'b1;
              end
            end else begin
              acc_d = frag_sum[FRAG_W] ? fpa_pkg::FRAG_MAX : frag_sum[FRAG_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.clear_count) begin
      freecnt_d = '0;
    end
  end

  // result
  always_comb begin
    code_d   = code_q;
    otaken_d = otaken_q;
    ofrag_d  = ofrag_q;
    if (cmd_i.load_out) begin
      code_d   = fpa_pkg::RES_OK;
      otaken_d = '0;
      ofrag_d  = '0;
      case (action_q)
        fpa_pkg::ACT_ALLOC: begin
          code_d   = alloc_ok ? fpa_pkg::RES_OK : fpa_pkg::RES_NO_MEMORY;
          otaken_d = taken_ext[fpa_pkg::TAKEN_W-1:0];
        end
        fpa_pkg::ACT_FREE: begin
          code_d = found_q ? fpa_pkg::RES_OK : fpa_pkg::RES_NOT_ALLOCATED;
        end
        fpa_pkg::ACT_QUERY: begin
          ofrag_d = acc_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q  <= '0;
      part_size_q <= DATA_W'(1);
      used_q      <= '0;
      n_q         <= '0;
      need_q      <= '0;
      idx_q       <= '0;
      pv_q        <= 1'b0;
      taken_q     <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == fpa_pkg::REG_MEMORY_SIZE)) begin
        mem_size_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == fpa_pkg::REG_PARTITION_SIZE)) begin
        part_size_q <= cfg_data_i;
      end
      used_q  <= used_d;
      n_q     <= n_d;
      need_q  <= need_d;
      idx_q   <= idx_d;
      pv_q    <= pv_d;
      taken_q <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      action_q <= fpa_pkg::fpa_action_e'(in_data_i[fpa_pkg::ACT_W-1:0]);
      pid_q    <= in_data_i[fpa_pkg::ACT_W +: PID_W];
      req_q    <= in_data_i[fpa_pkg::ACT_W + PID_W +: DATA_W];
    end
    pidx_q    <= idx_ix;
    freecnt_q <= freecnt_d;
    left_q    <= left_d;
    acc_q     <= acc_d;
    found_q   <= found_d;
    code_q    <= code_d;
    otaken_q  <= otaken_d;
    ofrag_q   <= ofrag_d;
  end

  assign out_data_o = {{OUT_PAD{1'b0}}, ofrag_q, otaken_q, code_q};

  `FPA_ASSERT(a_idx_bound, idx_q <= n_q, "partition index ran past the usable count")
  `FPA_ASSERT(a_taken_bound,
              (cmd_i.mode == fpa_pkg::MODE_ALLOC) |-> (DATA_W'(taken_q) <= need_q),
              "more partitions taken than requested")

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for fixed_partition_allocator: directed table, then random requests.
// Predicts allocate/free/query results in-bench; depends on fpa_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
  import fpa_pkg::*;

  localparam int unsigned MAX_PARTITIONS = 128;
  localparam int unsigned MAX_BYTES      = 24'hFFFFFF;
  localparam int unsigned CYCLE_LIMIT    = 3000000;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned DRAIN_CYCLES   = 400;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned PHASES         = 3;
  localparam int unsigned SEGMENTS       = 6;
  localparam int unsigned SEGMENT_ITEMS  = 96;
  localparam int unsigned PID_POOL       = 8;
  localparam int unsigned SRC_IDLE [PHASES]  = '{26, 75, 0};
  localparam int unsigned SINK_IDLE [PHASES] = '{75, 26, 0};

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    fpa_code_e           code;
    logic [TAKEN_W-1:0]  taken;
    logic [FRAG_W-1:0]   frag;
  } outcome_t;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    fpa_action_e          action;
    logic [PID_W-1:0]     pid;
    logic [DATA_W-1:0]    value;
    logic                 typed;
    outcome_t             outcome;
  } plan_row_t;

  localparam outcome_t NO_OUTCOME = '{RES_OK, 8'd0, 31'd0};
  localparam int unsigned PLAN_ROWS = 34;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0001, 24'd0, 1'b1,
      '{RES_OK, 8'd0, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0001, 24'd1, 1'b1,
      '{RES_NO_MEMORY, 8'd0, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_FREE, 16'h0001, 24'd0, 1'b1,
      '{RES_NOT_ALLOCATED, 8'd0, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_QUERY, 16'h0000, 24'd0, 1'b1,
      '{RES_OK, 8'd0, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_NONE, 16'hFFFF, 24'hFFFFFF, 1'b1,
      '{RES_OK, 8'd0, 31'd0}},
    '{ROW_CONFIG, REG_MEMORY_SIZE, ACT_NONE, 16'h0000, 24'd1000, 1'b0, NO_OUTCOME},
    '{ROW_CONFIG, REG_PARTITION_SIZE, ACT_NONE, 16'h0000, 24'd100, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0001, 24'd250, 1'b1,
      '{RES_OK, 8'd3, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_QUERY, 16'h0000, 24'd0, 1'b1,
      '{RES_OK, 8'd0, 31'd50}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'hFFFF, 24'd700, 1'b1,
      '{RES_OK, 8'd7, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0002, 24'd1, 1'b1,
      '{RES_NO_MEMORY, 8'd0, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_FREE, 16'h0001, 24'd0, 1'b1,
      '{RES_OK, 8'd0, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0000, 24'hFFFFFF, 1'b1,
      '{RES_NO_MEMORY, 8'd0, 31'd0}},
    '{ROW_CONFIG, REG_PARTITION_SIZE, ACT_NONE, 16'h0000, 24'd0, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0003, 24'd5, 1'b1,
      '{RES_NO_MEMORY, 8'd0, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0003, 24'd0, 1'b1,
      '{RES_OK, 8'd0, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_QUERY, 16'h0000, 24'd0, 1'b1,
      '{RES_OK, 8'd0, 31'd0}},
    '{ROW_CONFIG, REG_MEMORY_SIZE, ACT_NONE, 16'h0000, 24'hFFFFFF, 1'b0, NO_OUTCOME},
    '{ROW_CONFIG, REG_PARTITION_SIZE, ACT_NONE, 16'h0000, 24'd1, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0004, 24'd128, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0004, 24'd121, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_FREE, 16'hFFFF, 24'd0, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_FREE, 16'h0004, 24'd0, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0008, 24'd128, 1'b1,
      '{RES_OK, 8'd128, 31'd0}},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_FREE, 16'h0008, 24'd0, 1'b1,
      '{RES_OK, 8'd0, 31'd0}},
    '{ROW_CONFIG, REG_PARTITION_SIZE, ACT_NONE, 16'h0000, 24'hFFFFFF, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0005, 24'd1, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_QUERY, 16'h0000, 24'd0, 1'b1,
      '{RES_OK, 8'd0, 31'hFFFFFE}},
    '{ROW_CONFIG, REG_UNMAPPED, ACT_NONE, 16'h0000, 24'd0, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_QUERY, 16'h0000, 24'd0, 1'b1,
      '{RES_OK, 8'd0, 31'hFFFFFE}},
    '{ROW_CONFIG, REG_MEMORY_SIZE, ACT_NONE, 16'h0000, 24'd128, 1'b0, NO_OUTCOME},
    '{ROW_CONFIG, REG_PARTITION_SIZE, ACT_NONE, 16'h0000, 24'd1, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_ALLOC, 16'h0006, 24'd127, 1'b0, NO_OUTCOME},
    '{ROW_REQUEST, REG_MEMORY_SIZE, ACT_QUERY, 16'h0000, 24'd0, 1'b0, NO_OUTCOME}
  };

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [DATA_W-1:0]    cfg_data_i    = '0;

  logic              part_used  [MAX_PARTITIONS];
  logic [PID_W-1:0]  part_owner [MAX_PARTITIONS];
  logic [DATA_W-1:0] part_left  [MAX_PARTITIONS];
  logic [DATA_W-1:0] mem_bytes  = '0;
  logic [DATA_W-1:0] part_bytes = 24'd1;
  logic [PID_W-1:0]  pid_pool   [PID_POOL];

  outcome_t    pending_outcomes [$];
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_idle_pct  = 0;
  int unsigned hold_off_asked = 0;

  fixed_partition_allocator #(
    .MAX_PARTITIONS(MAX_PARTITIONS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned usable_partitions();
    int unsigned n;
    if (part_bytes == 0) return 0;
    n = int'(mem_bytes) / int'(part_bytes);
    return (n > MAX_PARTITIONS) ? MAX_PARTITIONS : n;
  endfunction

  function automatic outcome_t apply_request(fpa_action_e act, logic [PID_W-1:0] pid,
                                             logic [DATA_W-1:0] size);
    outcome_t          res;
    int unsigned       n, need, avail, taken, k;
    logic [DATA_W-1:0] left;
    longint unsigned   sum;
    logic              found;
    res = NO_OUTCOME;
    n = usable_partitions();
    case (act)
      ACT_ALLOC: begin
        need = 0;
        avail = 0;
        taken = 0;
        if (part_bytes != 0) need = (int'(size) + int'(part_bytes) - 1) / int'(part_bytes);
        else if (size != 0) need = 1;
        for (k = 0; k < n; k++) if (!part_used[k]) avail++;
        if (need <= avail) begin
          left = size;
          for (k = 0; k < n && taken < need; k++) begin
            if (!part_used[k]) begin
              part_owner[k] = pid;
              if (left >= part_bytes) begin
                part_left[k] = '0;
                left = left - part_bytes;
              end else begin
                part_left[k] = part_bytes - left;
                left = '0;
              end
              part_used[k] = 1'b1;
              taken++;
            end
          end
          res.taken = TAKEN_W'(taken);
        end else begin
          res.code = RES_NO_MEMORY;
        end
      end
      ACT_FREE: begin
        found = 1'b0;
        for (k = 0; k < n; k++) begin
          if (part_used[k] && part_owner[k] == pid) begin
            part_used[k] = 1'b0;
            part_owner[k] = '0;
            part_left[k] = '0;
            found = 1'b1;
          end
        end
        if (!found) res.code = RES_NOT_ALLOCATED;
      end
      ACT_QUERY: begin
        sum = 0;
        for (k = 0; k < n; k++) if (part_used[k]) sum += part_left[k];
        res.frag = (sum > FRAG_MAX) ? FRAG_MAX : sum[FRAG_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [PID_W-1:0] pick_pid(int unsigned n);
    int unsigned k;
    k = (n == 0) ? 0 : $urandom_range(n - 1);
    if (n != 0 && part_used[k] && $urandom_range(99) < 60) return part_owner[k];
    return pid_pool[$urandom_range(PID_POOL - 1)];
  endfunction

  function automatic logic [DATA_W-1:0] pick_size(int unsigned n);
    int unsigned     roll, span;
    longint unsigned bytes;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10 || part_bytes == 0) return DATA_W'($urandom);
    span = (n > 2) ? n / 2 + 1 : 2;
    bytes = longint'($urandom_range(span, 1) - 1) * part_bytes
            + $urandom_range(int'(part_bytes), 1);
    return (bytes > MAX_BYTES) ? DATA_W'(MAX_BYTES) : bytes[DATA_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_MEMORY_SIZE:    mem_bytes = value;
      REG_PARTITION_SIZE: part_bytes = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic offer_request(input fpa_action_e act, input logic [PID_W-1:0] pid,
                               input logic [DATA_W-1:0] size, input logic typed,
                               input outcome_t typed_out);
    outcome_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_W - IN_USED_W){1'b0}}, size, pid, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = apply_request(act, pid, size);
    pending_outcomes.push_back(typed ? typed_out : predicted);
  endtask

  task automatic reconfigure();
    int unsigned roll, ps, mem;
    roll = $urandom_range(99);
    if (roll < 50) begin
      ps = $urandom_range(300, 1);
      mem = ps * $urandom_range(16, 1) + $urandom_range(ps - 1, 0);
    end else if (roll < 70) begin
      ps = $urandom_range(2000, 1);
      mem = ps * MAX_PARTITIONS + $urandom_range(5000, 0);
    end else if (roll < 80) begin
      ps = $urandom_range(MAX_BYTES, 24'h100000);
      mem = MAX_BYTES;
    end else if (roll < 88) begin
      ps = 0;
      mem = $urandom_range(MAX_BYTES, 0);
    end else if (roll < 94) begin
      ps = $urandom_range(MAX_BYTES, 1);
      mem = $urandom_range(ps - 1, 0);
    end else begin
      ps = 1;
      mem = MAX_BYTES;
    end
    wait_idle();
    if ($urandom_range(1) == 0) begin
      write_reg(REG_MEMORY_SIZE, DATA_W'(mem));
      write_reg(REG_PARTITION_SIZE, DATA_W'(ps));
    end else begin
      write_reg(REG_PARTITION_SIZE, DATA_W'(ps));
      write_reg(REG_MEMORY_SIZE, DATA_W'(mem));
    end
    if ($urandom_range(9) == 0) write_reg(REG_UNMAPPED, DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : result_check
    outcome_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.code  = fpa_code_e'(m_axis_tdata[CODE_W-1:0]);
      got.taken = m_axis_tdata[CODE_W +: TAKEN_W];
      got.frag  = m_axis_tdata[CODE_W + TAKEN_W +: FRAG_W];
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("result with no request pending", 0, m_axis_tdata);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.code !== want.code) flag_mismatch("result_code", want.code, got.code);
        if (got.taken !== want.taken) flag_mismatch("partitions_taken", want.taken, got.taken);
        if (got.frag !== want.frag) flag_mismatch("fragmented_bytes", want.frag, got.frag);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_off_asked) begin
        hold_seen = hold_off_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : request_source
    int unsigned       i, phase, seg, sent, n, roll;
    logic              prev_config;
    fpa_action_e       act;
    logic [PID_W-1:0]  pid;
    logic [DATA_W-1:0] size;
    for (i = 0; i < MAX_PARTITIONS; i++) begin
      part_used[i] = 1'b0;
      part_owner[i] = '0;
      part_left[i] = '0;
    end
    for (i = 0; i < PID_POOL; i++) pid_pool[i] = PID_W'($urandom);
    src_idle_pct = SRC_IDLE[0];
    sink_idle_pct = SINK_IDLE[0];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    prev_config = 1'b0;
    for (i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_CONFIG) begin
        if (!prev_config) wait_idle();
        write_reg(PLAN[i].reg_index, PLAN[i].value);
        prev_config = 1'b1;
      end else begin
        if (prev_config) cfg_we_i <= 1'b0;
        prev_config = 1'b0;
        offer_request(PLAN[i].action, PLAN[i].pid, PLAN[i].value, PLAN[i].typed,
                      PLAN[i].outcome);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      src_idle_pct = SRC_IDLE[phase];
      sink_idle_pct = SINK_IDLE[phase];
      for (seg = 0; seg < SEGMENTS; seg++) begin
        reconfigure();
        for (i = 0; i < PID_POOL; i++) if ($urandom_range(1) == 1) pid_pool[i] = PID_W'($urandom);
        if (phase == PHASES - 1 && seg == 1) hold_off_asked++;
        sent = 0;
        while (sent < SEGMENT_ITEMS) begin
          n = usable_partitions();
          roll = $urandom_range(99);
          if (roll < 5) begin
            act = fpa_action_e'($urandom_range(3));
            pid = PID_W'($urandom);
            size = DATA_W'($urandom);
          end else if (roll < 9) begin
            act = ACT_NONE;
            pid = PID_W'($urandom);
            size = DATA_W'($urandom);
          end else if (roll < 55) begin
            act = ACT_ALLOC;
            pid = pick_pid(n);
            size = pick_size(n);
          end else if (roll < 82) begin
            act = ACT_FREE;
            pid = pick_pid(n);
            size = DATA_W'($urandom);
          end else begin
            act = ACT_QUERY;
            pid = PID_W'($urandom);
            size = DATA_W'($urandom);
          end
          offer_request(act, pid, size, 1'b0, NO_OUTCOME);
          if (act != ACT_NONE) sent++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
